// ===== rtl/unsigned_to_ascii_formatter_assert.svh =====
// ----------------------------------------------------------------------------
// unsigned_to_ascii_formatter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_ASCII_FORMATTER_ASSERT_SVH
`define UNSIGNED_TO_ASCII_FORMATTER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define UTOA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define UTOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/utoa_pkg.sv =====
// ----------------------------------------------------------------------------
// utoa_pkg
// Types, codes and helpers shared by the unsigned-to-ASCII formatter
// ----------------------------------------------------------------------------
package utoa_pkg;

  localparam int unsigned IN_VALUE_W      = 64;
  localparam int unsigned DEF_VALUE_WIDTH = 64;
  localparam int unsigned DEF_SHORT_WIDTH = 32;

  localparam logic [7:0] ASCII_ZERO    = 8'd48;
  localparam logic [7:0] ASCII_X       = 8'h78;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd39;

  typedef enum logic [1:0] {
    MODE_DEC = 2'd0,
    MODE_OCT = 2'd1,
    MODE_HEX = 2'd2,
    MODE_RSV = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ZERO,
    ST_DABBLE,
    ST_PREFIX0,
    ST_PREFIXX,
    ST_SKIP,
    ST_DIGITS
  } state_e;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [1:0]            mode;
    logic                  long_size;
    logic                  alternate_form;
    logic                  precision_zero;
  } utoa_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } utoa_out_t;

  // control of the digit shift register
  typedef struct packed {
    logic load;      // capture a new value
    logic load_dec;  // clear bcd field, keep binary for double dabble
    logic dabble;    // one double-dabble bit step
    logic shift;     // drop the top digit
    logic nib4;      // 4-bit digits (hex, bcd), else 3-bit (octal)
  } utoa_sr_ctrl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    c = {4'h0, d} + ASCII_ZERO;
    if (d > 4'd9) begin
      c = c + HEX_ALPHA_OFS;
    end
    return c;
  endfunction

endpackage

// ===== rtl/utoa_digit_sr.sv =====
// ----------------------------------------------------------------------------
// utoa_digit_sr
// Digit shift register: bit-serial binary to bcd and top-digit readout
// ----------------------------------------------------------------------------
module utoa_digit_sr #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned DIGIT_W     = 84
) (
  input  logic                   clk_i,
  input  utoa_pkg::utoa_sr_ctrl_t ctrl_i,
  input  logic [VALUE_WIDTH-1:0] load_val_i,
  input  logic [VALUE_WIDTH-1:0] load_bin_i,
  output logic [3:0]             top_digit_o
);
  import utoa_pkg::*;

  localparam int unsigned NIBBLES = DIGIT_W / 4;

  logic [DIGIT_W-1:0]     dig_q;
  logic [DIGIT_W-1:0]     dig_d;
  logic [DIGIT_W-1:0]     adj;
  logic [VALUE_WIDTH-1:0] bin_q;
  logic [VALUE_WIDTH-1:0] bin_d;

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < NIBBLES; i++) begin
      if (dig_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = dig_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    dig_d = dig_q;
    bin_d = bin_q;
    if (ctrl_i.load) begin
      bin_d = load_bin_i;
      if (ctrl_i.load_dec) begin
        dig_d = '0;
      end else begin
        dig_d = {{(DIGIT_W-VALUE_WIDTH){1'b0}}, load_val_i};
      end
    end else if (ctrl_i.dabble) begin
      dig_d = {adj[DIGIT_W-2:0], bin_q[VALUE_WIDTH-1]};
      bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
    end else if (ctrl_i.shift) begin
      if (ctrl_i.nib4) begin
        dig_d = {dig_q[DIGIT_W-5:0], 4'h0};
      end else begin
        dig_d = {dig_q[DIGIT_W-4:0], 3'h0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    bin_q <= bin_d;
  end

  assign top_digit_o = ctrl_i.nib4 ? dig_q[DIGIT_W-1 -: 4] : {1'b0, dig_q[DIGIT_W-1 -: 3]};

endmodule

// ===== rtl/unsigned_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_ascii_formatter
// Unsigned decimal / octal / hex to ASCII conversion, one character per beat
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries one conversion request per
// transaction; output channel out_valid_o/out_ready_i carries one ASCII
// character per transaction, last set on the final character of a request.
// Requests are handled one at a time: in_ready_o is high only while idle.
// Octal and hex digits are read straight off a shift register, top digit
// first, 3 or 4 bits a cycle; a receiver stall holds each character. Decimal
// first runs a bit-serial double dabble, one input bit per cycle, over
// VALUE_WIDTH bits long or SHORT_WIDTH short. The readout skips leading zero
// digit slots of the 84-bit digit register, then leaves the skip and emits
// the characters. A zero value gives the single character 0, or none when
// precision_zero suppresses it. Reset empties the output register and
// returns the controller to idle. A stalled receiver holds the current
// character in the output register and the next character waits; nothing
// is dropped.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_formatter #(
  parameter int unsigned VALUE_WIDTH = utoa_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned SHORT_WIDTH = utoa_pkg::DEF_SHORT_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  utoa_pkg::utoa_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output utoa_pkg::utoa_out_t out_data_o
);
  import utoa_pkg::*;

  `include "unsigned_to_ascii_formatter_assert.svh"

  localparam int unsigned DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned DIGIT_W    = 12 * ((4 * DEC_DIGITS + 11) / 12);
  localparam int unsigned GCW        = $clog2(DIGIT_W / 3 + 1);
  localparam int unsigned BCW        = $clog2(VALUE_WIDTH + 1);

  state_e          state_q, state_d;
  logic [GCW-1:0]  grp_cnt_q, grp_cnt_d;
  logic [BCW-1:0]  bit_cnt_q, bit_cnt_d;
  logic            hex_q, hex_d;
  logic            dec_q, dec_d;
  logic            out_valid_q, out_valid_d;
  utoa_out_t       out_q, out_d;

  utoa_sr_ctrl_t          sr_ctrl;
  logic [3:0]             top_digit;
  logic [VALUE_WIDTH-1:0] val_long;
  logic [VALUE_WIDTH-1:0] val_short;
  logic [VALUE_WIDTH-1:0] load_val;
  logic [VALUE_WIDTH-1:0] load_bin;
  logic                   val_zero;
  logic                   in_hs;
  logic                   can_emit;
  logic                   emit;
  utoa_out_t              emit_data;
  logic                   in_oct;
  logic                   in_hex;

  assign val_long  = in_data_i.value[VALUE_WIDTH-1:0];
  assign val_short = {{(VALUE_WIDTH-SHORT_WIDTH){1'b0}}, in_data_i.value[SHORT_WIDTH-1:0]};
  assign load_val  = in_data_i.long_size ? val_long : val_short;
  // left-align so the double dabble sees the top bit of the used width first
  assign load_bin  = in_data_i.long_size ? val_long
                                         : (val_short << (VALUE_WIDTH - SHORT_WIDTH));
  assign val_zero  = (load_val == '0);
  assign in_oct    = (in_data_i.mode == MODE_OCT);
  assign in_hex    = (in_data_i.mode == MODE_HEX);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_hs      = in_valid_i && in_ready_o;
  assign can_emit   = !out_valid_q || out_ready_i;

  utoa_digit_sr #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .DIGIT_W    (DIGIT_W)
  ) u_digit_sr (
    .clk_i      (clk_i),
    .ctrl_i     (sr_ctrl),
    .load_val_i (load_val),
    .load_bin_i (load_bin),
    .top_digit_o(top_digit)
  );

  always_comb begin
    state_d   = state_q;
    grp_cnt_d = grp_cnt_q;
    bit_cnt_d = bit_cnt_q;
    hex_d     = hex_q;
    dec_d     = dec_q;
    emit      = 1'b0;
    emit_data = '{character: ASCII_ZERO, last: 1'b0};
    sr_ctrl   = '{load: 1'b0, load_dec: 1'b0, dabble: 1'b0, shift: 1'b0, nib4: !hex_q && !dec_q
                  ? 1'b0 : 1'b1};

    unique case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          hex_d = in_hex;
          dec_d = !in_oct && !in_hex;
          grp_cnt_d = in_oct ? GCW'(DIGIT_W / 3) : GCW'(DIGIT_W / 4);
          bit_cnt_d = in_data_i.long_size ? BCW'(VALUE_WIDTH) : BCW'(SHORT_WIDTH);
          sr_ctrl.load     = 1'b1;
          sr_ctrl.load_dec = !in_oct && !in_hex;
          if (val_zero) begin
            state_d = in_data_i.precision_zero ? ST_IDLE : ST_ZERO;
          end else if (!in_oct && !in_hex) begin
            state_d = ST_DABBLE;
          end else if (in_data_i.alternate_form) begin
            state_d = ST_PREFIX0;
          end else begin
            state_d = ST_SKIP;
          end
        end
      end
      ST_ZERO: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_data = '{character: ASCII_ZERO, last: 1'b1};
          state_d   = ST_IDLE;
        end
      end
      ST_DABBLE: begin
        sr_ctrl.dabble = 1'b1;
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == BCW'(1)) begin
          state_d = ST_SKIP;
        end
      end
      ST_PREFIX0: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_data = '{character: ASCII_ZERO, last: 1'b0};
          state_d   = hex_q ? ST_PREFIXX : ST_SKIP;
        end
      end
      ST_PREFIXX: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_data = '{character: ASCII_X, last: 1'b0};
          state_d   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zero digits; the value is nonzero so one digit stops this
        if (top_digit == 4'd0 && grp_cnt_q != GCW'(1)) begin
          sr_ctrl.shift = 1'b1;
          grp_cnt_d = grp_cnt_q - 1'b1;
        end else begin
          state_d = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (can_emit) begin
          emit          = 1'b1;
          emit_data     = '{character: digit_char(top_digit), last: grp_cnt_q == GCW'(1)};
          sr_ctrl.shift = 1'b1;
          grp_cnt_d     = grp_cnt_q - 1'b1;
          if (grp_cnt_q == GCW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_data;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grp_cnt_q   <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      grp_cnt_q   <= grp_cnt_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hex_q <= hex_d;
    dec_q <= dec_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `UTOA_ASSERT_SAME(a_grp_nonzero, (state_q == ST_SKIP || state_q == ST_DIGITS),
                    grp_cnt_q != '0, "digit group count ran out during readout")
  `UTOA_ASSERT_SAME(a_skip_finds_digit, state_q == ST_SKIP && grp_cnt_q == GCW'(1),
                    top_digit != 4'd0, "leading zero skip reached the last digit")
  `UTOA_ASSERT_SAME(a_bcd_digit, state_q == ST_DIGITS && dec_q,
                    top_digit <= 4'd9, "decimal digit out of range")
  `UTOA_ASSERT_NEXT(a_last_ends, emit && emit_data.last,
                    state_q == ST_IDLE, "controller busy after final character")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for unsigned_to_ascii_formatter: a table of directed
// requests (zero, precision zero, extremes, every mode and prefix) and then
// random requests, sent in bursts while the receiver stalls on its own
// pattern. Every character is checked against typed text or a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import utoa_pkg::*;

  localparam int unsigned RANDOM_REQS = 470;

  typedef struct {
    utoa_in_t req;
    bit       typed;  // text below is the expected output
    string    text;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  utoa_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  utoa_out_t out_data;

  utoa_out_t   expected_chars[$];
  utoa_out_t   want;
  dir_row_t    dir_rows[$];
  int          errors = 0;
  int          burst_left = 0;
  logic [15:0] ready_pattern = '1;
  int          pattern_cycles = 0;

  unsigned_to_ascii_formatter dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // printf-style text of one request, queued character by character
  function automatic void predict_conversion(input utoa_in_t req);
    logic [63:0] v;
    logic [63:0] radix;
    logic [7:0]  digit;
    logic [7:0]  text[$];
    v = req.long_size ? req.value : {32'd0, req.value[31:0]};
    if (v == '0) begin
      if (!req.precision_zero) begin
        text.push_back(ASCII_ZERO);
      end
    end else begin
      case (mode_e'(req.mode))
        MODE_OCT: radix = 64'd8;
        MODE_HEX: radix = 64'd16;
        default:  radix = 64'd10;
      endcase
      while (v != '0) begin
        digit = 8'(v % radix);
        // '0'..'9', then 'a'..'f'
        text.push_front(digit < 8'd10 ? digit + 8'd48 : digit + 8'd87);
        v = v / radix;
      end
      if (req.alternate_form && radix == 64'd16) begin
        text.push_front(ASCII_X);
        text.push_front(ASCII_ZERO);
      end else if (req.alternate_form && radix == 64'd8) begin
        text.push_front(ASCII_ZERO);
      end
    end
    foreach (text[i]) begin
      expected_chars.push_back('{character: text[i], last: (i == text.size() - 1)});
    end
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      expected_chars.push_back('{character: s[i], last: (i == s.len() - 1)});
    end
  endfunction

  function automatic void add_row(input logic [63:0] v, input mode_e m, input bit long_sz,
                                  input bit alt, input bit pz, input bit typed,
                                  input string s);
    dir_row_t row;
    row.req.value          = v;
    row.req.mode           = m;
    row.req.long_size      = long_sz;
    row.req.alternate_form = alt;
    row.req.precision_zero = pz;
    row.typed              = typed;
    row.text               = s;
    dir_rows.push_back(row);
  endfunction

  function automatic utoa_in_t random_req();
    utoa_in_t r;
    r.value = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: r.value = '0;
      1: r.value = 64'($urandom_range(0, 40));
      2, 3, 4: r.value = r.value >> $urandom_range(0, 63);
      5: r.value = {r.value[63:32], 32'd0};  // zero once cut to 32 bits
      default: ;
    endcase
    r.mode           = ($urandom_range(0, 7) == 0) ? MODE_RSV : 2'($urandom_range(0, 2));
    r.long_size      = 1'($urandom);
    r.alternate_form = 1'($urandom);
    r.precision_zero = 1'($urandom);
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_req(input utoa_in_t req, input bit typed, input string s);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      push_text(s);
    end else begin
      predict_conversion(req);
    end
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
    end
  endtask

  // receiver: rotating ready pattern, reloaded every so often
  always @(posedge clk) begin
    if (pattern_cycles == 0) begin
      case ($urandom_range(0, 2))
        0: ready_pattern <= '1;
        1: ready_pattern <= 16'($urandom);
        default: ready_pattern <= 16'($urandom) | 16'($urandom);
      endcase
      pattern_cycles <= $urandom_range(50, 250);
    end else begin
      ready_pattern  <= {ready_pattern[0], ready_pattern[15:1]};
      pattern_cycles <= pattern_cycles - 1;
    end
    out_ready <= ready_pattern[0];
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, got %h last %b",
                 $time, out_data.character, out_data.last);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.character !== want.character) begin
          $display("%0t: character mismatch: expected %h, got %h",
                   $time, want.character, out_data.character);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch: expected %b, got %b", $time, want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  initial begin
    add_row(64'd0, MODE_DEC, 1'b1, 1'b0, 1'b0, 1'b1, "0");
    add_row(64'd0, MODE_HEX, 1'b1, 1'b1, 1'b0, 1'b1, "0");
    add_row(64'd0, MODE_OCT, 1'b0, 1'b1, 1'b1, 1'b1, "");
    add_row(64'hffff_ffff_0000_0000, MODE_HEX, 1'b0, 1'b1, 1'b1, 1'b1, "");
    add_row(64'hffff_ffff_0000_0000, MODE_OCT, 1'b0, 1'b1, 1'b0, 1'b1, "0");
    add_row('1, MODE_DEC, 1'b1, 1'b0, 1'b0, 1'b1, "18446744073709551615");
    add_row('1, MODE_DEC, 1'b0, 1'b1, 1'b1, 1'b1, "4294967295");
    add_row('1, MODE_OCT, 1'b1, 1'b1, 1'b0, 1'b1, "01777777777777777777777");
    add_row('1, MODE_OCT, 1'b1, 1'b0, 1'b1, 1'b1, "1777777777777777777777");
    add_row('1, MODE_HEX, 1'b1, 1'b1, 1'b0, 1'b1, "0xffffffffffffffff");
    add_row('1, MODE_HEX, 1'b0, 1'b0, 1'b0, 1'b1, "ffffffff");
    add_row('1, MODE_OCT, 1'b0, 1'b1, 1'b0, 1'b1, "037777777777");
    add_row(64'd1, MODE_DEC, 1'b1, 1'b1, 1'b1, 1'b1, "1");
    add_row(64'd1, MODE_RSV, 1'b0, 1'b1, 1'b0, 1'b1, "1");
    add_row(64'd8, MODE_OCT, 1'b0, 1'b1, 1'b0, 1'b1, "010");
    add_row(64'd10, MODE_HEX, 1'b1, 1'b0, 1'b0, 1'b1, "a");
    add_row(64'hdead_beef, MODE_HEX, 1'b0, 1'b1, 1'b0, 1'b1, "0xdeadbeef");
    add_row(64'h0123_4567_89ab_cdef, MODE_HEX, 1'b1, 1'b1, 1'b1, 1'b1, "0x123456789abcdef");
    add_row(64'h1_0000_0000, MODE_DEC, 1'b1, 1'b0, 1'b0, 1'b1, "4294967296");
    add_row(64'd255, MODE_RSV, 1'b1, 1'b1, 1'b0, 1'b0, "");
    add_row(64'h8000_0000_0000_0000, MODE_OCT, 1'b1, 1'b1, 1'b0, 1'b0, "");
    add_row(64'd1000000, MODE_DEC, 1'b0, 1'b0, 1'b1, 1'b0, "");
    add_row(64'hfedc_ba98_7654_3210, MODE_RSV, 1'b1, 1'b1, 1'b1, 1'b0, "");
    add_row(64'h5555_5555_aaaa_aaaa, MODE_OCT, 1'b0, 1'b0, 1'b0, 1'b0, "");

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].text);
    end
    for (int n = 0; n < RANDOM_REQS; n++) begin
      send_req(random_req(), 1'b0, "");
    end
    if (burst_left != 0) begin
      in_valid <= 1'b0;
    end

    while (expected_chars.size() != 0) @(posedge clk);
    // watch for stray characters
    repeat (200) @(posedge clk);

    if (expected_chars.size() != 0) begin
      $display("%0t: %0d characters still expected", $time, expected_chars.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
